/* src/whc_pkg.sv */
package whc_pkg;

    localparam int unsigned POS_W = 6;
    localparam int unsigned FS_W = 33;
    localparam int unsigned WORD_W = 32;

    localparam logic [POS_W-1:0] HDR_LEN = 6'd44;
    localparam logic [POS_W-1:0] LAST_POS = 6'd43;
    localparam logic [POS_W-1:0] RIFF_SIZE_POS = 6'd7;
    localparam logic [FS_W-1:0] HDR_LEN_WIDE = 33'd44;
    localparam logic [FS_W-1:0] RIFF_OVERHEAD = 33'd36;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BAD,
        KIND_FMT
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_VALID,
        STATUS_MALFORMED,
        STATUS_UNSUPPORTED
    } status_t;

    typedef struct packed {
        status_t status;
        logic [WORD_W-1:0] data_bytes;
        logic [POS_W-1:0] data_offset;
    } result_t;

    function automatic logic [7:0] expect_byte(input logic [POS_W-1:0] pos);
        logic [7:0] value;
        case (pos)
            6'd0: value = 8'h52;
            6'd1: value = 8'h49;
            6'd2: value = 8'h46;
            6'd3: value = 8'h46;
            6'd8: value = 8'h57;
            6'd9: value = 8'h41;
            6'd10: value = 8'h56;
            6'd11: value = 8'h45;
            6'd12: value = 8'h66;
            6'd13: value = 8'h6D;
            6'd14: value = 8'h74;
            6'd15: value = 8'h20;
            6'd16: value = 8'h10;
            6'd20: value = 8'h01;
            6'd22: value = 8'h01;
            6'd24: value = 8'h80;
            6'd25: value = 8'h3E;
            6'd29: value = 8'h7D;
            6'd32: value = 8'h02;
            6'd34: value = 8'h10;
            6'd36: value = 8'h64;
            6'd37: value = 8'h61;
            6'd38: value = 8'h74;
            6'd39: value = 8'h61;
            default: value = 8'h00;
        endcase
        return value;
    endfunction

    function automatic kind_t check_kind(input logic [POS_W-1:0] pos);
        kind_t kind;
        if (pos inside {[6'd0:6'd3], [6'd8:6'd19], [6'd36:6'd39]}) begin
            kind = KIND_BAD;
        end
        else if (pos inside {[6'd20:6'd35]}) begin
            kind = KIND_FMT;
        end
        else begin
            kind = KIND_NONE;
        end
        return kind;
    endfunction

endpackage

/* src/whc_parser.sv */
module whc_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [7:0]                     hdr_byte,
    input  logic                           last,
    input  logic [whc_pkg::FS_W-1:0]       file_size,
    output logic                           res_valid,
    output whc_pkg::result_t               res
);

    logic [whc_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       bad_reg, bad_next;
    logic                       fmt_reg, fmt_next;
    logic [whc_pkg::WORD_W-1:0] word_reg, word_next;
    logic [whc_pkg::WORD_W-1:0] riff_reg, riff_next;
    logic                       skip_reg, skip_next;

    logic [whc_pkg::POS_W-1:0]  pos_c;
    logic [whc_pkg::POS_W-1:0]  pos_inc;
    whc_pkg::kind_t             kind;
    logic                       mismatch;
    logic                       bad_c;
    logic                       fmt_c;
    logic [whc_pkg::WORD_W-1:0] word_c;
    logic [whc_pkg::WORD_W-1:0] riff_c;
    logic                       at_end;
    logic                       fs_small;
    logic [whc_pkg::FS_W-1:0]   fs_limit;
    logic                       data_big;
    logic                       riff_bad;
    logic                       final_bad;

    always_comb
    begin
        pos_c = (pos_reg >= whc_pkg::HDR_LEN) ? whc_pkg::LAST_POS : pos_reg;
        pos_inc = pos_c + 6'd1;
        kind = whc_pkg::check_kind(pos_c);
        mismatch = (hdr_byte != whc_pkg::expect_byte(pos_c));
        bad_c = bad_reg | ((kind == whc_pkg::KIND_BAD) & mismatch);
        fmt_c = fmt_reg | ((kind == whc_pkg::KIND_FMT) & mismatch);
        word_c = {hdr_byte, word_reg[whc_pkg::WORD_W-1:8]};
        riff_c = (pos_c == whc_pkg::RIFF_SIZE_POS) ? word_c : riff_reg;
        at_end = (pos_inc == whc_pkg::HDR_LEN);
        fs_small = (file_size < whc_pkg::HDR_LEN_WIDE);
        fs_limit = file_size - whc_pkg::HDR_LEN_WIDE;
        data_big = ({1'b0, word_c} > fs_limit);
        riff_bad = ({1'b0, riff_c} != ({1'b0, word_c} + whc_pkg::RIFF_OVERHEAD));
        final_bad = bad_c | fs_small | data_big | riff_bad;
    end

    always_comb
    begin
        pos_next = pos_reg;
        bad_next = bad_reg;
        fmt_next = fmt_reg;
        word_next = word_reg;
        riff_next = riff_reg;
        skip_next = skip_reg;
        if (step) begin
            if (skip_reg) begin
                if (last) begin
                    skip_next = 1'b0;
                end
            end
            else if (at_end || last) begin
                pos_next = '0;
                bad_next = 1'b0;
                fmt_next = 1'b0;
                word_next = '0;
                riff_next = '0;
                skip_next = at_end & ~last;
            end
            else begin
                pos_next = pos_inc;
                bad_next = bad_c;
                fmt_next = fmt_c;
                word_next = word_c;
                riff_next = riff_c;
            end
        end
    end

    always_comb
    begin
        res_valid = step & ~skip_reg & (at_end | last);
        res.status = whc_pkg::STATUS_MALFORMED;
        res.data_bytes = '0;
        res.data_offset = '0;
        if (at_end && !final_bad) begin
            if (fmt_c) begin
                res.status = whc_pkg::STATUS_UNSUPPORTED;
            end
            else begin
                res.status = whc_pkg::STATUS_VALID;
                res.data_bytes = word_c;
                res.data_offset = whc_pkg::HDR_LEN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0;
            bad_reg <= 1'b0;
            fmt_reg <= 1'b0;
            word_reg <= '0;
            riff_reg <= '0;
            skip_reg <= 1'b0;
        end
        else begin
            pos_reg <= pos_next;
            bad_reg <= bad_next;
            fmt_reg <= fmt_next;
            word_reg <= word_next;
            riff_reg <= riff_next;
            skip_reg <= skip_next;
        end
    end

    // A header in progress never reaches its full length without restarting.
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg < whc_pkg::HDR_LEN)
        else $error("byte position ran past the header length");

    // While trailing bytes are being dropped no new header has started.
    assert property (@(posedge clk) disable iff (!rst_n) skip_reg |-> (pos_reg == '0))
        else $error("header parse advanced while skipping trailing bytes");

    // Every result closes the current header.
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |=> (pos_reg == '0))
        else $error("header did not restart after a result");

endmodule

/* src/whc_out_reg.sv */
module whc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  whc_pkg::result_t  res,
    input  logic              out_stall,
    output logic              ready,
    output logic              out_valid,
    output whc_pkg::result_t  out_res
);

    logic             valid_reg, valid_next;
    whc_pkg::result_t res_reg, res_next;

    assign ready = ~valid_reg | ~out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        res_next = res_reg;
        if (load) begin
            valid_next = 1'b1;
            res_next = res;
        end
        else if (valid_reg && !out_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res = res_reg;

endmodule

/* src/wav_header_checker_unit.sv */
// An accepted header byte waits in the input register while the output register is stalled; the
// parser then steps on it, and a result it causes is loaded into and presented by the output register.
// Throughput: one byte per cycle unless stalled, via the single register-to-register parse stage.
// Reset clears the parse state, the skip flag, both valid flags and the file size register.
module wav_header_checker_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [whc_pkg::FS_W-1:0]  file_size,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                header_byte,
    input  logic                      last_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [31:0]               data_bytes,
    output logic [5:0]                data_offset
);

    logic [whc_pkg::FS_W-1:0] file_size_reg;
    logic                     in_valid_reg, in_valid_next;
    logic [7:0]               byte_reg;
    logic                     last_reg;
    logic                     in_accept;
    logic                     out_ready;
    logic                     step;
    logic                     res_valid;
    whc_pkg::result_t         res;
    whc_pkg::result_t         out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            file_size_reg <= '0;
        end
        else if (cfg_valid) begin
            file_size_reg <= file_size;
        end
    end

    assign in_stall = in_valid_reg & ~out_ready;
    assign in_accept = in_valid & ~in_stall;
    assign step = in_valid_reg & out_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end
        else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            byte_reg <= header_byte;
            last_reg <= last_byte;
        end
    end

    whc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .hdr_byte  (byte_reg),
        .last      (last_reg),
        .file_size (file_size_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    whc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign status = out_res.status;
    assign data_bytes = out_res.data_bytes;
    assign data_offset = out_res.data_offset;

endmodule
